// ----- rtl/core/rbpa_pkg.sv -----
// Shared types, widths and constants of the beam pointing angle block.
// No dependencies; imported by every rbpa module and the top level.
package rbpa_pkg;

  localparam int PHASE_W      = 32;  // CORDIC phase, 2^32 per turn
  localparam int ACC_W        = 34;  // phase accumulator
  localparam int CORDIC_W     = 38;  // CORDIC x/y datapath
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int TRIG_W       = 32;  // Q30 sine / cosine
  localparam int OP_W         = 33;  // multiplier operand
  localparam int MAG_W        = 32;  // multiplier operand magnitude
  localparam int PROD_W       = 65;  // multiplier result
  localparam int ROOT_W       = 31;
  localparam int RAD_W        = 61;  // square root radicand
  localparam int WIND_W       = 17;
  localparam int TILT_W       = 16;
  localparam int CFG_W        = 3;
  localparam int VEC_W        = 36;  // x, y, z sums

  localparam logic signed [CORDIC_W-1:0] GAIN_INV = 38'sd652032874;

  localparam logic [CFG_W-1:0] CFG_AFT_SINE    = 3'd0;
  localparam logic [CFG_W-1:0] CFG_AFT_COSINE  = 3'd1;
  localparam logic [CFG_W-1:0] CFG_FORE_SINE   = 3'd2;
  localparam logic [CFG_W-1:0] CFG_FORE_COSINE = 3'd3;
  localparam logic [CFG_W-1:0] CFG_WAVEGUIDE   = 3'd4;

  typedef struct packed {
    logic start;
    logic vector_mode;
  } rbpa_cordic_cmd_t;

  typedef struct packed {
    logic start;
    logic negate;
    logic round;
  } rbpa_mul_cmd_t;

  function automatic logic [PHASE_W-1:0] atan_phase(input logic [STEP_W-1:0] i);
    logic [PHASE_W-1:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/rbpa_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle: rotation mode gives Q30
// sine/cosine of a phase, vectoring mode gives the angle of (x, y). Uses rbpa_pkg.
module rbpa_cordic import rbpa_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  rbpa_cordic_cmd_t            cmd,
  input  logic [PHASE_W-1:0]          phase,
  input  logic signed [CORDIC_W-1:0]  xin,
  input  logic signed [CORDIC_W-1:0]  yin,
  output logic signed [TRIG_W-1:0]    sin_val,
  output logic signed [TRIG_W-1:0]    cos_val,
  output logic signed [ACC_W-1:0]     angle,
  output logic                        done
);

  localparam logic signed [CORDIC_W-1:0] ONE     = 38'sd1073741824;
  localparam logic signed [CORDIC_W-1:0] NEG_ONE = -38'sd1073741824;

  logic signed [CORDIC_W-1:0] x, y, xs, ys, cx, cy;
  logic signed [ACC_W-1:0]    acc, at;
  logic                       vmode, flip, busy, q_flip;
  logic [STEP_W-1:0]          iter;
  logic [PHASE_W-1:0]         pf;

  assign q_flip = phase[PHASE_W-1] ^ phase[PHASE_W-2];
  assign pf     = {phase[PHASE_W-1] ^ q_flip, phase[PHASE_W-2:0]};
  assign xs     = x >>> iter;
  assign ys     = y >>> iter;
  assign at     = $signed({2'b00, atan_phase(iter)});
  assign cx     = flip ? -x : x;
  assign cy     = flip ? -y : y;
  assign angle  = acc;

  always_comb begin
    if (cx > ONE) begin
      cos_val = ONE[TRIG_W-1:0];
    end else if (cx < NEG_ONE) begin
      cos_val = NEG_ONE[TRIG_W-1:0];
    end else begin
      cos_val = cx[TRIG_W-1:0];
    end
    if (cy > ONE) begin
      sin_val = ONE[TRIG_W-1:0];
    end else if (cy < NEG_ONE) begin
      sin_val = NEG_ONE[TRIG_W-1:0];
    end else begin
      sin_val = cy[TRIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        iter  <= '0;
        vmode <= cmd.vector_mode;
        if (!cmd.vector_mode) begin
          x    <= GAIN_INV;
          y    <= '0;
          acc  <= {{(ACC_W-PHASE_W){pf[PHASE_W-1]}}, pf};
          flip <= q_flip;
        end else if (xin < 0) begin
          x    <= -xin;
          y    <= -yin;
          acc  <= 34'sd2147483648;
          flip <= 1'b0;
        end else begin
          x    <= xin;
          y    <= yin;
          acc  <= '0;
          flip <= 1'b0;
        end
      end else if (busy) begin
        if (vmode ? (y > 0) : (acc < 0)) begin
          x   <= x + ys;
          y   <= y - xs;
          acc <= acc + at;
        end else begin
          x   <= x - ys;
          y   <= y + xs;
          acc <= acc - at;
        end
        iter <= iter + 1'b1;
        if (iter == STEP_W'(CORDIC_STEPS-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/rbpa_mul.sv -----
// Digit-serial signed multiplier, four multiplier bits per cycle, with
// optional product negation and rounding to Q30. Uses rbpa_pkg.
module rbpa_mul import rbpa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  rbpa_mul_cmd_t            cmd,
  input  logic signed [OP_W-1:0]   a,
  input  logic signed [OP_W-1:0]   b,
  output logic signed [PROD_W-1:0] res,
  output logic                     done
);

  logic [OP_W-1:0]         aa, ab;
  logic [MAG_W-1:0]        ma, mb;
  logic [2*MAG_W-1:0]      acc;
  logic [MAG_W+3:0]        pp;
  logic signed [PROD_W-1:0] p;
  logic                    sgn, rnd_q, busy, fin;
  logic [2:0]              cnt;

  assign aa = a[OP_W-1] ? -a : a;
  assign ab = b[OP_W-1] ? -b : b;
  assign pp = (MAG_W+4)'(ma) * (MAG_W+4)'(mb[MAG_W-1:MAG_W-4]);
  assign p  = sgn ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (cmd.start) begin
        ma    <= aa[MAG_W-1:0];
        mb    <= ab[MAG_W-1:0];
        sgn   <= a[OP_W-1] ^ b[OP_W-1] ^ cmd.negate;
        rnd_q <= cmd.round;
        acc   <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        acc <= (acc << 4) + (2*MAG_W)'(pp);
        mb  <= mb << 4;
        cnt <= cnt + 1'b1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        res  <= rnd_q ? ((p + 65'sd536870912) >>> 30) : p;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/rbpa_isqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
// Uses rbpa_pkg.
module rbpa_isqrt import rbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [RAD_W-1:0] rem, bitv;
  logic [RAD_W:0]   r, trial;
  logic             busy;

  assign trial = r + {1'b0, bitv};
  assign root  = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= rad;
        r    <= '0;
        bitv <= {1'b1, {(RAD_W-1){1'b0}}};
        busy <= 1'b1;
      end else if (busy) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[RAD_W-1:0];
          r   <= (r >> 1) + {1'b0, bitv};
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/radar_beam_pointing_angles_top.sv -----
// Beam pointing angles of a twin aft/fore airborne radar: sequencer, config
// registers and held angles. Uses rbpa_pkg, rbpa_cordic, rbpa_mul, rbpa_isqrt.
//
//   channel  direction  handshake              payload
//   s_*      in         s_tvalid/s_tready      ray: angles, attitude, wind
//   m_*      out        m_tvalid/m_tready      azimuth, elevation, wind
//   cfg_*    in         cfg_write              tilt sin/cos, waveguide switch
//
// One ray runs from acceptance to m_tvalid through four CORDIC sine/cosine runs,
// twenty products on the digit-serial multiplier, a square root, two CORDIC
// vectoring runs and an output state, all in sequence; the azimuth vectoring run
// is skipped when the azimuth is held. The next ray is taken only after the output state.
// Reset is synchronous; held azimuth/elevation clear to zero.
// s_tready is high only while idle; a finished result waits in the output
// register and the next ray may be taken meanwhile; a second finished ray
// waits in the output state until the first transaction is taken.
module radar_beam_pointing_angles_top import rbpa_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_W-1:0]     cfg_index,
  input  logic [TILT_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // antenna_angle, roll, heading, pitch, tilt_negative, wind_dir, wind_spd
  input  logic [((5*ANGLE_BITS+TILT_W+1+7)/8)*8-1:0] s_tdata,
  // radar_select
  input  logic [0:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // azimuth, elevation, east_west_wind, north_south_wind
  output logic [((2*ANGLE_BITS+2*WIND_W+7)/8)*8-1:0] m_tdata,
  // azimuth_fresh
  output logic [0:0]           m_tuser
);

  localparam int AB    = ANGLE_BITS;
  localparam int SH    = PHASE_W - AB;
  localparam int OUT_W = ((2*AB+2*WIND_W+7)/8)*8;
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(64'd1 << (SH-1));
  localparam logic signed [ACC_W-1:0] EL_LIM  = ACC_W'(64'd1 << (AB-2));
  localparam logic signed [ACC_W-1:0] EL_NLIM = -EL_LIM;
  localparam logic signed [PROD_W-1:0] WMAX   = 65'sd65535;
  localparam logic signed [PROD_W-1:0] WMIN   = -65'sd65535;
  localparam logic signed [VEC_W-1:0]  ZONE   = 36'sd1073741824;
  localparam logic signed [VEC_W-1:0]  ZNONE  = -36'sd1073741824;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_TRIG_WAIT, S_MUL, S_MUL_WAIT, S_SQRT, S_SQRT_WAIT,
    S_AZ, S_AZ_WAIT, S_EL, S_EL_WAIT, S_OUT
  } state_t;

  state_t state;

  logic [TILT_W-1:0] aft_sine, aft_cosine, fore_sine, fore_cosine;
  logic              waveguide_on_aft;

  logic                 sel, tneg;
  logic [AB-1:0]        rot_sum, heading, pitch, wdir;
  logic [TILT_W-1:0]    speed;
  logic [1:0]           tstep;
  logic [4:0]           mstep;
  logic signed [TRIG_W-1:0] sc, cc, sh, ch, sp, cp, sw, cw, zc;
  logic signed [OP_W-1:0]   t, st, ct, op_a, op_b;
  logic signed [VEC_W-1:0]  x, y, z;
  logic signed [WIND_W-1:0] ew, ns, wind_c;
  logic [RAD_W-1:0]     sq;
  logic [AB-1:0]        az_q, el_q, az_new, el_new;
  logic                 fresh;
  logic [AB-1:0]        held_az [2];
  logic [AB-1:0]        held_el [2];

  rbpa_cordic_cmd_t           ccmd;
  rbpa_mul_cmd_t              mcmd;
  logic [PHASE_W-1:0]         cphase;
  logic signed [CORDIC_W-1:0] cxin, cyin;
  logic signed [TRIG_W-1:0]   csin, ccos;
  logic signed [ACC_W-1:0]    cangle, rv;
  logic                       cdone, mdone, sdone;
  logic signed [PROD_W-1:0]   mres;
  logic [ROOT_W-1:0]          root;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      aft_sine         <= '0;
      aft_cosine       <= 16'h4000;
      fore_sine        <= '0;
      fore_cosine      <= 16'h4000;
      waveguide_on_aft <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_AFT_SINE:    aft_sine         <= cfg_data;
        CFG_AFT_COSINE:  aft_cosine       <= cfg_data;
        CFG_FORE_SINE:   fore_sine        <= cfg_data;
        CFG_FORE_COSINE: fore_cosine      <= cfg_data;
        CFG_WAVEGUIDE:   waveguide_on_aft <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign st = OP_W'($signed({sel ? fore_sine : aft_sine, 16'b0}));
  assign ct = OP_W'($signed({sel ? fore_cosine : aft_cosine, 16'b0}));

  assign s_tready = (state == S_IDLE);

  // trig phase select
  always_comb begin
    case (tstep)
      2'd0:    cphase = {rot_sum, {SH{1'b0}}};
      2'd1:    cphase = {heading, {SH{1'b0}}};
      2'd2:    cphase = {pitch, {SH{1'b0}}};
      default: cphase = {wdir, {SH{1'b0}}};
    endcase
  end

  always_comb begin
    if (z > ZONE) begin
      zc = ZONE[TRIG_W-1:0];
    end else if (z < ZNONE) begin
      zc = ZNONE[TRIG_W-1:0];
    end else begin
      zc = z[TRIG_W-1:0];
    end
  end

  // product schedule
  always_comb begin
    mcmd.start  = (state == S_MUL);
    mcmd.negate = 1'b0;
    mcmd.round  = 1'b1;
    case (mstep)
      5'd0:    begin op_a = OP_W'(sw); op_b = $signed({17'b0, speed}); mcmd.negate = 1'b1; end
      5'd1:    begin op_a = OP_W'(cw); op_b = $signed({17'b0, speed}); mcmd.negate = 1'b1; end
      5'd2:    begin op_a = OP_W'(cc); op_b = OP_W'(sh); end
      5'd3:    begin op_a = t;         op_b = ct;        end
      5'd4:    begin op_a = t;         op_b = OP_W'(sp); end
      5'd5:    begin op_a = OP_W'(ch); op_b = OP_W'(sc); end
      5'd6:    begin op_a = t;         op_b = ct;        end
      5'd7:    begin op_a = OP_W'(sh); op_b = OP_W'(cp); end
      5'd8:    begin op_a = t;         op_b = st;        end
      5'd9:    begin op_a = OP_W'(cc); op_b = OP_W'(ch); end
      5'd10:   begin op_a = t;         op_b = ct;        end
      5'd11:   begin op_a = t;         op_b = OP_W'(sp); end
      5'd12:   begin op_a = OP_W'(sh); op_b = OP_W'(sc); end
      5'd13:   begin op_a = t;         op_b = ct;        end
      5'd14:   begin op_a = OP_W'(cp); op_b = OP_W'(ch); end
      5'd15:   begin op_a = t;         op_b = st;        end
      5'd16:   begin op_a = OP_W'(cp); op_b = ct;        end
      5'd17:   begin op_a = t;         op_b = OP_W'(cc); end
      5'd18:   begin op_a = OP_W'(sp); op_b = st;        end
      default: begin op_a = OP_W'(zc); op_b = OP_W'(zc); mcmd.round = 1'b0; end
    endcase
  end

  always_comb begin
    if (mres > WMAX) begin
      wind_c = WMAX[WIND_W-1:0];
    end else if (mres < WMIN) begin
      wind_c = WMIN[WIND_W-1:0];
    end else begin
      wind_c = mres[WIND_W-1:0];
    end
  end

  assign ccmd.start       = (state == S_TRIG) || (state == S_EL) ||
                            ((state == S_AZ) && ((x != 0) || (y != 0)));
  assign ccmd.vector_mode = (state != S_TRIG);
  assign cxin = (state == S_AZ) ? CORDIC_W'(y) : $signed({7'b0, root});
  assign cyin = (state == S_AZ) ? CORDIC_W'(x) : CORDIC_W'(zc);

  assign rv     = (cangle + HALF) >>> SH;
  assign az_new = rv[AB-1:0];
  assign el_new = (rv > EL_LIM) ? EL_LIM[AB-1:0] :
                  (rv < EL_NLIM) ? EL_NLIM[AB-1:0] : rv[AB-1:0];

  rbpa_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ccmd),
    .phase   (cphase),
    .xin     (cxin),
    .yin     (cyin),
    .sin_val (csin),
    .cos_val (ccos),
    .angle   (cangle),
    .done    (cdone)
  );

  rbpa_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mcmd),
    .a    (op_a),
    .b    (op_b),
    .res  (mres),
    .done (mdone)
  );

  rbpa_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SQRT),
    .rad   ({1'b1, 60'b0} - sq),
    .root  (root),
    .done  (sdone)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      held_az[0] <= '0;
      held_az[1] <= '0;
      held_el[0] <= '0;
      held_el[1] <= '0;
    end else begin
      if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sel     <= s_tuser[0];
            rot_sum <= s_tdata[0 +: AB] + s_tdata[AB +: AB];
            heading <= s_tdata[2*AB +: AB];
            pitch   <= s_tdata[3*AB +: AB];
            tneg    <= s_tdata[4*AB];
            wdir    <= s_tdata[4*AB+1 +: AB];
            speed   <= s_tdata[5*AB+1 +: TILT_W];
            tstep   <= '0;
            state   <= S_TRIG;
          end
        end
        S_TRIG: state <= S_TRIG_WAIT;
        S_TRIG_WAIT: begin
          if (cdone) begin
            case (tstep)
              2'd0:    begin sc <= csin; cc <= ccos; end
              2'd1:    begin sh <= csin; ch <= ccos; end
              2'd2:    begin sp <= csin; cp <= ccos; end
              default: begin sw <= csin; cw <= ccos; end
            endcase
            if (tstep == 2'd3) begin
              mstep <= '0;
              state <= S_MUL;
            end else begin
              tstep <= tstep + 1'b1;
              state <= S_TRIG;
            end
          end
        end
        S_MUL: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mdone) begin
            case (mstep)
              5'd0:  ew <= wind_c;
              5'd1:  ns <= wind_c;
              5'd4:  x  <= -mres[VEC_W-1:0];
              5'd6,
              5'd8:  x  <= x + mres[VEC_W-1:0];
              5'd11: y  <= -mres[VEC_W-1:0];
              5'd13: y  <= y - mres[VEC_W-1:0];
              5'd15: y  <= y + mres[VEC_W-1:0];
              5'd17: z  <= mres[VEC_W-1:0];
              5'd18: z  <= z + mres[VEC_W-1:0];
              5'd19: sq <= mres[RAD_W-1:0];
              default: t <= mres[OP_W-1:0];
            endcase
            if (mstep == 5'd19) begin
              state <= S_SQRT;
            end else begin
              mstep <= mstep + 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_SQRT: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sdone) begin
            state <= S_AZ;
          end
        end
        S_AZ: begin
          if ((x == 0) && (y == 0)) begin
            az_q  <= held_az[sel];
            fresh <= 1'b0;
            state <= S_EL;
          end else begin
            state <= S_AZ_WAIT;
          end
        end
        S_AZ_WAIT: begin
          if (cdone) begin
            az_q         <= az_new;
            held_az[sel] <= az_new;
            fresh        <= 1'b1;
            state        <= S_EL;
          end
        end
        S_EL: state <= S_EL_WAIT;
        S_EL_WAIT: begin
          if (cdone) begin
            el_q         <= el_new;
            held_el[sel] <= el_new;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            // fore ray under the aft waveguide takes the aft held angles
            if (sel && tneg && waveguide_on_aft) begin
              m_tdata    <= OUT_W'({ns, ew, held_el[0], held_az[0]});
              m_tuser[0] <= 1'b0;
            end else begin
              m_tdata    <= OUT_W'({ns, ew, el_q, az_q});
              m_tuser[0] <= fresh;
            end
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for radar_beam_pointing_angles_top: directed and random rays
// are checked against an in-bench beam pointing predictor. Depends on rbpa_pkg and the RTL.
module testbench import rbpa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  IN_W        = ((5*16+TILT_W+1+7)/8)*8;
  localparam int  OUT_W       = ((2*16+2*WIND_W+7)/8)*8;
  localparam longint ONE_Q30  = 64'sd1 << 30;
  localparam longint WIND_LIM = 65535;
  localparam longint EL_LIM   = 16384;
  localparam int  LIMIT       = 8000000;
  localparam logic [CFG_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam int  CFG_SPARE_COUNT = 3;

  typedef struct {
    logic               radar_select;
    logic        [15:0] antenna_angle;
    logic signed [15:0] roll;
    logic        [15:0] heading;
    logic signed [15:0] pitch;
    logic               tilt_negative;
    logic        [15:0] wind_dir;
    logic        [15:0] wind_spd;
  } ray_t;

  typedef struct {
    logic        [15:0] azimuth;
    logic        [15:0] elevation;
    logic               azimuth_fresh;
    logic        [16:0] east_west_wind;
    logic        [16:0] north_south_wind;
  } beam_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_index = '0;
  logic [TILT_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  radar_beam_pointing_angles_top dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [15:0] tilt_reg [4];
  logic        waveguide_aft;
  logic [15:0] held_az [2];
  logic [15:0] held_el [2];

  beam_t  beam_q [$];
  int     fail_count = 0;
  int     cycle = 0;
  bit     no_idle = 1'b0;
  bit     hold_req = 1'b0;
  bit     hold_done = 1'b0;

  const longint arctan [20] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304};

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v < -lim ? -lim : (v > lim ? lim : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic void rotate_trig(logic [15:0] ang, output longint s, output longint c);
    logic [31:0] p;
    bit flip;
    longint x, y, acc, xn, yn;
    p = {ang, 16'h0};
    flip = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
    if (flip) p = p - 32'h8000_0000;
    acc = longint'($signed(p));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      if (acc >= 0) begin
        xn = x - (y >>> i); yn = y + (x >>> i); acc -= arctan[i];
      end else begin
        xn = x + (y >>> i); yn = y - (x >>> i); acc += arctan[i];
      end
      x = xn; y = yn;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(x, ONE_Q30);
    s = clip(y, ONE_Q30);
  endfunction

  function automatic longint vector_phase(longint xv, longint yv);
    longint acc, xn, yn;
    acc = 0;
    if (xv < 0) begin
      xv = -xv; yv = -yv; acc = 64'sd1 <<< 31;
    end
    for (int i = 0; i < 20; i++) begin
      if (yv > 0) begin
        xn = xv + (yv >>> i); yn = yv - (xv >>> i); acc += arctan[i];
      end else begin
        xn = xv - (yv >>> i); yn = yv + (xv >>> i); acc -= arctan[i];
      end
      xv = xn; yv = yn;
    end
    return acc;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic beam_t predict_beam(ray_t r);
    beam_t  b;
    int     sel;
    longint st, ct, sc, cc, sh, ch, sp, cp, sw, cw, x, y, z, root, el, spd;
    logic [15:0] rot;
    sel = r.radar_select;
    st = longint'($signed(tilt_reg[sel ? CFG_FORE_SINE : CFG_AFT_SINE])) * 65536;
    ct = longint'($signed(tilt_reg[sel ? CFG_FORE_COSINE : CFG_AFT_COSINE])) * 65536;
    rot = r.antenna_angle + r.roll;
    rotate_trig(rot, sc, cc);
    rotate_trig(r.heading, sh, ch);
    rotate_trig(r.pitch, sp, cp);
    rotate_trig(r.wind_dir, sw, cw);
    spd = r.wind_spd;
    b.east_west_wind   = 17'(clip(round_shift(-(sw * spd), 30), WIND_LIM));
    b.north_south_wind = 17'(clip(round_shift(-(cw * spd), 30), WIND_LIM));
    x = -qmul(qmul(qmul(cc, sh), ct), sp) + qmul(qmul(ch, sc), ct) + qmul(qmul(sh, cp), st);
    y = -qmul(qmul(qmul(cc, ch), ct), sp) - qmul(qmul(sh, sc), ct) + qmul(qmul(cp, ch), st);
    z = qmul(qmul(cp, ct), cc) + qmul(sp, st);
    if (x != 0 || y != 0) begin
      b.azimuth = 16'(round_shift(vector_phase(y, x), 16));
      held_az[sel] = b.azimuth;
      b.azimuth_fresh = 1'b1;
    end else begin
      b.azimuth = held_az[sel];
      b.azimuth_fresh = 1'b0;
    end
    z = clip(z, ONE_Q30);
    root = int_sqrt(longint'(ONE_Q30 * ONE_Q30) - z * z);
    el = clip(round_shift(vector_phase(root, z), 16), EL_LIM);
    held_el[sel] = 16'(el);
    b.elevation = 16'(el);
    if (sel == 1 && r.tilt_negative && waveguide_aft) begin
      b.azimuth = held_az[0];
      b.elevation = held_el[0];
      b.azimuth_fresh = 1'b0;
    end
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  task automatic send_ray(ray_t r);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.radar_select;
    s_tdata  <= {7'b0, r.wind_spd, r.wind_dir, r.tilt_negative,
                 r.pitch, r.heading, r.roll, r.antenna_angle};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    beam_q.push_back(predict_beam(r));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    wait (beam_q.size() == 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_WAVEGUIDE) waveguide_aft = val[0];
    else if (idx < CFG_WAVEGUIDE) tilt_reg[idx] = val;
  endtask

  task automatic set_tilts(int as, int ac, int fs, int fc, bit wg);
    write_reg(CFG_AFT_SINE, 16'(as));
    write_reg(CFG_AFT_COSINE, 16'(ac));
    write_reg(CFG_FORE_SINE, 16'(fs));
    write_reg(CFG_FORE_COSINE, 16'(fc));
    write_reg(CFG_WAVEGUIDE, 16'(wg));
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h4000 * 16'($urandom_range(0, 3));
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    r.radar_select   = 1'($urandom_range(0, 1));
    r.antenna_angle  = pick_angle();
    r.roll           = pick_angle();
    r.heading        = pick_angle();
    r.pitch          = pick_angle();
    r.tilt_negative  = 1'($urandom_range(0, 1));
    r.wind_dir       = pick_angle();
    r.wind_spd       = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    return r;
  endfunction

  function automatic ray_t make_ray(bit sel, logic [15:0] rot, logic [15:0] rl,
                                    logic [15:0] hd, logic [15:0] pt, bit tn,
                                    logic [15:0] wd, logic [15:0] ws);
    ray_t r;
    r.radar_select = sel; r.antenna_angle = rot; r.roll = rl; r.heading = hd;
    r.pitch = pt; r.tilt_negative = tn; r.wind_dir = wd; r.wind_spd = ws;
    return r;
  endfunction

  function automatic int rand_tilt();
    case ($urandom_range(0, 5))
      0: return -16384;
      1: return 16384;
      2: return 0;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      stall_left <= 1500;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400) : $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    beam_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (beam_q.size() == 0) begin
        $error("unexpected result transaction: %h", m_tdata);
        fail_count++;
      end else begin
        e = beam_q.pop_front();
        if (m_tdata[15:0] !== e.azimuth) begin
          $error("azimuth exp %0d got %0d", e.azimuth, m_tdata[15:0]); fail_count++;
        end
        if (m_tdata[31:16] !== e.elevation) begin
          $error("elevation exp %0d got %0d", $signed(e.elevation), $signed(m_tdata[31:16]));
          fail_count++;
        end
        if (m_tuser[0] !== e.azimuth_fresh) begin
          $error("azimuth_fresh exp %0d got %0d", e.azimuth_fresh, m_tuser[0]); fail_count++;
        end
        if (m_tdata[48:32] !== e.east_west_wind) begin
          $error("east_west_wind exp %0d got %0d", $signed(e.east_west_wind),
                 $signed(m_tdata[48:32])); fail_count++;
        end
        if (m_tdata[65:49] !== e.north_south_wind) begin
          $error("north_south_wind exp %0d got %0d", $signed(e.north_south_wind),
                 $signed(m_tdata[65:49])); fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_ray(make_ray(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000));
    send_ray(make_ray(1, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 1, 16'hFFFF, 16'hFFFF));
    send_ray(make_ray(0, 16'h4000, 16'h8000, 16'hC000, 16'h8000, 1, 16'h4000, 16'hFFFF));
    send_ray(make_ray(1, 16'h8000, 16'h0001, 16'h8000, 16'hC000, 0, 16'hC000, 16'h8000));
    wait_idle();
  endtask

  task automatic test_zero_horizontal();
    // zero tilt vector: x = y = z = 0, azimuth held
    set_tilts(0, 0, 0, 0, 0);
    send_ray(make_ray(0, 16'h1234, 16'h0000, 16'h2000, 16'h0100, 0, 16'h0000, 16'h0100));
    send_ray(make_ray(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 16'h8000, 16'h0000));
    wait_idle();
    // vertical beam: tilt 90 deg, pitch 90 deg (fore: -90 deg each), then one ray at pitch 0
    set_tilts(16384, 0, -16384, 0, 0);
    send_ray(make_ray(0, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 0, 16'h2000, 16'h1000));
    send_ray(make_ray(1, 16'h3000, 16'h0000, 16'h5000, 16'hC000, 0, 16'h6000, 16'h2000));
    send_ray(make_ray(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000));
    wait_idle();
  endtask

  task automatic test_waveguide_override();
    set_tilts(-16384, 16384, 16384, -16384, 1);
    send_ray(make_ray(1, 16'h2000, 16'h0000, 16'h1000, 16'h0000, 1, 16'h0000, 16'h0010));
    send_ray(make_ray(0, 16'h3000, 16'h0100, 16'h4000, 16'h0200, 0, 16'h1000, 16'h0020));
    send_ray(make_ray(1, 16'h5000, 16'hFF00, 16'h0000, 16'h0300, 1, 16'h2000, 16'h0030));
    send_ray(make_ray(1, 16'h5000, 16'hFF00, 16'h0000, 16'h0300, 0, 16'h2000, 16'h0030));
    send_ray(make_ray(0, 16'h6000, 16'h0000, 16'h0000, 16'h0000, 1, 16'h3000, 16'h0040));
    wait_idle();
    for (int k = 0; k < CFG_SPARE_COUNT; k++) write_reg(CFG_SPARE_FIRST + CFG_W'(k), 16'hFFFF);
    send_ray(make_ray(1, 16'h7000, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0001));
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      set_tilts(rand_tilt(), rand_tilt(), rand_tilt(), rand_tilt(), ph[0]);
      no_idle = (ph == 2);
      for (int n = 0; n < 255; n++) send_ray(random_ray());
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    set_tilts(11585, 11585, -11585, 11585, 1);
    hold_req = 1'b1;
    for (int n = 0; n < 8; n++) send_ray(random_ray());
    wait_idle();
  endtask

  initial begin
    tilt_reg[CFG_AFT_SINE] = 16'd0;
    tilt_reg[CFG_AFT_COSINE] = 16'd16384;
    tilt_reg[CFG_FORE_SINE] = 16'd0;
    tilt_reg[CFG_FORE_COSINE] = 16'd16384;
    waveguide_aft = 1'b0;
    held_az = '{16'd0, 16'd0};
    held_el = '{16'd0, 16'd0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_horizontal();
    test_waveguide_override();
    test_backpressure();
    test_random_phases();
    wait (beam_q.size() == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
